[rtl/assert_macros.svh]
// Assertion macros used by the checker file, stg_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Plain clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/stg_pkg.sv]
// Types, constants and the sine table for the shape trajectory generator.
// Depends on nothing.
`default_nettype none
package stg_pkg;
	localparam int unsigned PHASE_BITS_DEF = 16;
	localparam int unsigned SINE_DEPTH_DEF = 256;

	localparam logic [2:0] CFG_PHASE_RATE = 3'd0;
	localparam logic [2:0] CFG_BLEND_RATE = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_X   = 3'd2;
	localparam logic [2:0] CFG_ORIGIN_Y   = 3'd3;
	localparam logic [2:0] CFG_PIX_PER_CM = 3'd4;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic [2:0] SHP_NONE   = 3'd0;
	localparam logic [2:0] SHP_LINE_H = 3'd1;
	localparam logic [2:0] SHP_LINE_V = 3'd2;
	localparam logic [2:0] SHP_SQUARE = 3'd3;
	localparam logic [2:0] SHP_TRI    = 3'd4;
	localparam logic [2:0] SHP_CIRCLE = 3'd5;
	localparam logic [2:0] SHP_FIG8   = 3'd6;
	localparam logic [2:0] SHP_HEART  = 3'd7;

	typedef struct packed {
		logic        cmd;
		logic [15:0] time_step;
		logic [2:0]  new_shape;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
	} stg_in_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
	} stg_out_t;

	typedef struct packed {
		logic        start;
		logic        tick;
	} stg_cmd_t;

	typedef struct packed {
		logic        done;
	} stg_sts_t;

	// Quarter-wave sine entry, Q1.15, from an integer Taylor series.
	function automatic logic [16:0] sine_entry(input int unsigned i, input int unsigned depth);
		logic [63:0] x, x2, term, sum;
		logic [63:0] v;
		logic        neg;
		x = (64'd1686629713 * 64'(i)) / 64'(depth);
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		neg = 1'b0;
		for (int n = 1; n <= 5; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) sum = sum - term;
			else sum = sum + term;
		end
		neg = sum[63];
		if (neg) sum = '0;
		v = (sum + 64'd16384) >> 15;
		if (v > 64'd32768) v = 64'd32768;
		return v[16:0];
	endfunction
endpackage
`default_nettype wire

[rtl/stg_ctrl.sv]
// Sequencer for the trajectory generator: handshakes and datapath commands.
// Depends on stg_pkg.
`default_nettype none
module stg_ctrl
	import stg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     in_cmd,
	output logic          out_valid,
	input  wire logic     out_ready,
	output stg_cmd_t      dp_cmd,
	input  wire stg_sts_t dp_sts
);
	typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_HOLD} state_t;
	state_t state_q;

	// Accept only when idle, or when the held result is taken this cycle.
	always_comb begin
		in_ready = (state_q == ST_IDLE) || (state_q == ST_HOLD && out_ready);
		dp_cmd.start = in_valid && in_ready && (in_cmd == CMD_START);
		dp_cmd.tick  = in_valid && in_ready && (in_cmd == CMD_TICK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (dp_cmd.tick) state_q <= ST_BUSY;
				end
				ST_BUSY: begin
					if (dp_sts.done) begin
						state_q <= ST_HOLD;
						out_valid <= 1'b1;
					end
				end
				ST_HOLD: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= dp_cmd.tick ? ST_BUSY : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/stg_dpath.sv]
// Datapath: phase and blend state, shape point, screen map and blend.
// Depends on stg_pkg. Runs a fixed step sequence for each tick item.
`default_nettype none
module stg_dpath
	import stg_pkg::*;
#(
	parameter int unsigned PHASE_BITS = PHASE_BITS_DEF,
	parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire stg_cmd_t    cmd,
	input  wire stg_in_t     in_item,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_data,
	output stg_sts_t         sts,
	output stg_out_t         result
);
	localparam int unsigned DW = $clog2(SINE_TABLE_DEPTH);

	// Configuration registers.
	logic [19:0] phase_rate_q, blend_rate_q;
	logic signed [15:0] origin_x_q, origin_y_q;
	logic [15:0] ppcm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_rate_q <= 20'd6554;
			blend_rate_q <= 20'd65536;
			origin_x_q <= '0;
			origin_y_q <= '0;
			ppcm_q <= 16'd1280;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PHASE_RATE: phase_rate_q <= cfg_data[19:0];
				CFG_BLEND_RATE: blend_rate_q <= cfg_data[19:0];
				CFG_ORIGIN_X:   origin_x_q <= cfg_data[15:0];
				CFG_ORIGIN_Y:   origin_y_q <= cfg_data[15:0];
				CFG_PIX_PER_CM: ppcm_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sine table as constant logic.
	logic [16:0] rom [SINE_TABLE_DEPTH+1];
	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		assign rom[g] = sine_entry(g, SINE_TABLE_DEPTH);
	end

	function automatic logic signed [17:0] sin_lu(input logic [15:0] a,
		input logic [16:0] r [SINE_TABLE_DEPTH+1]);
		logic [DW+1:0] idx;
		logic [DW-1:0] k;
		logic [16:0] m;
		idx = (DW+2)'(({16'd0, a} * 32'(4 * SINE_TABLE_DEPTH)) >> 16);
		k = idx[DW-1:0];
		m = idx[DW] ? r[SINE_TABLE_DEPTH - 32'(k)] : r[k];
		return idx[DW+1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	// Sequence step counter.
	typedef enum logic [3:0] {
		SP_IDLE, SP_ADV, SP_BLEND, SP_TRIG, SP_HEART1, SP_HEART2, SP_WORLD,
		SP_SCRX, SP_SCRY, SP_SAT, SP_MIX, SP_OUT
	} step_t;
	step_t step_q;

	logic [PHASE_BITS-1:0] phase_q;
	logic [16:0] blend_q;
	logic [2:0]  shape_q;
	logic signed [15:0] from_x_q, from_y_q;
	logic [15:0] dt_q;
	logic [35:0] pinc_q, binc_q;
	logic [15:0] a_q;
	logic [33:0] bsq_q;
	logic [16:0] s_q;
	logic signed [17:0] sn1_q, cs1_q, sn2_q, cs2_q, cs3_q, cs4_q;
	logic signed [35:0] sq9_q;
	logic signed [53:0] cube_q;
	logic signed [31:0] wx_q, wy_q;
	logic signed [63:0] px_q, py_q;
	logic signed [15:0] tx_q, ty_q;
	logic signed [33:0] mx_q, my_q;
	stg_out_t res_q;

	// Phase cut to Q0.16.
	logic [15:0] a16;
	always_comb begin
		if (PHASE_BITS >= 16) a16 = 16'(phase_q >> (PHASE_BITS - 16));
		else a16 = 16'({phase_q, 16'd0} >> PHASE_BITS);
	end

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7FFF;
		if (v < -64'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// World point of the active shape, Q16.16 cm.
	logic signed [47:0] wx_c, wy_c;
	always_comb begin
		logic [17:0] p3;
		logic [1:0] seg;
		logic signed [47:0] sv;
		logic signed [47:0] hx, hy;
		p3 = 18'(a_q) * 18'd3;
		sv = '0;
		seg = '0;
		hx = '0;
		hy = '0;
		wx_c = '0;
		wy_c = 48'sd50 <<< 16;
		case (shape_q)
			SHP_LINE_H: begin
				sv = 48'({a_q[14:0], 1'b0});
				wx_c = a_q[15] ? (48'sd45 <<< 16) - 90 * sv : -(48'sd45 <<< 16) + 90 * sv;
				wy_c = 48'sd45 <<< 16;
			end
			SHP_LINE_V: begin
				sv = 48'({a_q[14:0], 1'b0});
				wx_c = '0;
				wy_c = a_q[15] ? (48'sd83 <<< 16) - 60 * sv : (48'sd23 <<< 16) + 60 * sv;
			end
			SHP_SQUARE: begin
				sv = 48'({a_q[13:0], 2'b0});
				case (a_q[15:14])
					2'd0: begin wx_c = -(48'sd15 <<< 16) + 30 * sv; wy_c = 48'sd35 <<< 16; end
					2'd1: begin wx_c = 48'sd15 <<< 16; wy_c = (48'sd35 <<< 16) + 30 * sv; end
					2'd2: begin wx_c = (48'sd15 <<< 16) - 30 * sv; wy_c = 48'sd65 <<< 16; end
					default: begin wx_c = -(48'sd15 <<< 16); wy_c = (48'sd65 <<< 16) - 30 * sv; end
				endcase
			end
			SHP_TRI: begin
				seg = p3[17:16];
				sv = 48'(p3[15:0]);
				case (seg)
					2'd0: begin wx_c = 15 * sv; wy_c = (48'sd68 <<< 16) - 27 * sv; end
					2'd1: begin wx_c = (48'sd15 <<< 16) - 30 * sv; wy_c = 48'sd41 <<< 16; end
					default: begin wx_c = -(48'sd15 <<< 16) + 15 * sv; wy_c = (48'sd41 <<< 16) + 27 * sv; end
				endcase
			end
			SHP_CIRCLE: begin
				wx_c = 30 * 48'(cs1_q);
				wy_c = (48'sd50 <<< 16) + 30 * 48'(sn1_q);
			end
			SHP_FIG8: begin
				wx_c = 30 * 48'(sn1_q);
				wy_c = (48'sd50 <<< 16) + 15 * 48'(sn2_q);
			end
			SHP_HEART: begin
				hx = 48'(cube_q >>> 29);
				hy = 39 * 48'(cs1_q) - 15 * 48'(cs2_q) - 6 * 48'(cs3_q) - 3 * 48'(cs4_q);
				wx_c = hx;
				wy_c = (48'sd50 <<< 16) + (hy >>> 1);
			end
			default: ;
		endcase
	end

	// Blend advance, saturating at one; the increment can reach 20 bits.
	logic [16:0] nb;
	always_comb begin
		logic [20:0] sum;
		sum = 21'(blend_q) + 21'(binc_q[35:16]);
		nb = (sum > 21'd65536) ? 17'd65536 : sum[16:0];
	end

	// Smoothstep product, b*b*(3 - 2b) in Q0.16 steps.
	logic [51:0] s_full;
	assign s_full = bsq_q * (18'd196608 - {blend_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= SP_IDLE;
			phase_q <= '0;
			blend_q <= '0;
			shape_q <= SHP_NONE;
			from_x_q <= '0;
			from_y_q <= '0;
			sts.done <= 1'b0;
		end else begin
			sts.done <= 1'b0;
			unique case (step_q)
				SP_IDLE: begin
					if (cmd.start) begin
						shape_q <= in_item.new_shape;
						from_x_q <= in_item.start_x;
						from_y_q <= in_item.start_y;
						blend_q <= '0;
					end else if (cmd.tick) begin
						dt_q <= in_item.time_step;
						step_q <= SP_ADV;
					end
				end
				SP_ADV: begin
					pinc_q <= phase_rate_q * dt_q;
					binc_q <= blend_rate_q * dt_q;
					step_q <= SP_BLEND;
				end
				SP_BLEND: begin
					phase_q <= phase_q + PHASE_BITS'(pinc_q >> (32 - PHASE_BITS));
					blend_q <= nb;
					bsq_q <= nb * nb;
					step_q <= SP_TRIG;
				end
				SP_TRIG: begin
					a_q <= a16;
					s_q <= s_full[48:32];
					sn1_q <= sin_lu(a16, rom);
					cs1_q <= sin_lu(a16 + 16'd16384, rom);
					sn2_q <= sin_lu(16'(a16 * 2), rom);
					cs2_q <= sin_lu(16'(a16 * 2) + 16'd16384, rom);
					cs3_q <= sin_lu(16'(a16 * 3) + 16'd16384, rom);
					cs4_q <= sin_lu(16'(a16 * 4) + 16'd16384, rom);
					step_q <= SP_HEART1;
				end
				SP_HEART1: begin
					sq9_q <= sn1_q * sn1_q * 36'sd9;
					step_q <= SP_HEART2;
				end
				SP_HEART2: begin
					cube_q <= sq9_q * sn1_q;
					step_q <= SP_WORLD;
				end
				SP_WORLD: begin
					// world points stay well inside 32 bits
					wx_q <= wx_c[31:0];
					wy_q <= wy_c[31:0];
					step_q <= SP_SCRX;
				end
				SP_SCRX: begin
					px_q <= wx_q * $signed({1'b0, ppcm_q});
					step_q <= SP_SCRY;
				end
				SP_SCRY: begin
					py_q <= wy_q * $signed({1'b0, ppcm_q});
					step_q <= SP_SAT;
				end
				SP_SAT: begin
					tx_q <= sat16(64'(origin_x_q) + (px_q >>> 20));
					ty_q <= sat16(64'(origin_y_q) - (py_q >>> 20));
					step_q <= SP_MIX;
				end
				SP_MIX: begin
					mx_q <= $signed({1'b0, s_q}) * (34'(tx_q) - 34'(from_x_q));
					my_q <= $signed({1'b0, s_q}) * (34'(ty_q) - 34'(from_y_q));
					step_q <= SP_OUT;
				end
				SP_OUT: begin
					res_q.pos_x <= sat16(64'(from_x_q) + 64'(mx_q >>> 16));
					res_q.pos_y <= sat16(64'(from_y_q) + 64'(my_q >>> 16));
					sts.done <= 1'b1;
					step_q <= SP_IDLE;
				end
				default: step_q <= SP_IDLE;
			endcase
		end
	end

	assign result = res_q;
endmodule
`default_nettype wire

[rtl/shape_trajectory_generator_core.sv]
// Shape trajectory generator: a test path source for a robot arm.
// A start item latches shape and start point and gives no result; a tick item
// gives one result once the step sequence of the datapath has run through
// (two multiplies per step at most). One item at a time; a new item is
// taken in the cycle its predecessor's result is taken. Depends on stg_pkg.
`default_nettype none
module shape_trajectory_generator_core
	import stg_pkg::*;
#(
	parameter int unsigned PHASE_BITS = PHASE_BITS_DEF,
	parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire stg_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output stg_out_t         out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	stg_cmd_t dp_cmd;
	stg_sts_t dp_sts;

	assign cfg_ready = 1'b1;

	stg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_cmd(in_data.cmd), .out_valid(out_valid), .out_ready(out_ready),
		.dp_cmd(dp_cmd), .dp_sts(dp_sts)
	);

	stg_dpath #(.PHASE_BITS(PHASE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(dp_cmd), .in_item(in_data),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.sts(dp_sts), .result(out_data)
	);
endmodule
`default_nettype wire

[rtl/stg_checker.sv]
// Port-level checker for the trajectory generator, bound to the top level.
// Depends on stg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module stg_checker
	import stg_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire stg_in_t  in_data,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire stg_out_t out_data
);
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped")
	`ASSERT_CLK(a_start_quiet, clk, arst_n, in_valid && in_ready && in_data.cmd == CMD_START && !out_valid |=> !out_valid, "start item gave a result")
	`ASSERT_CLK(a_tick_busy, clk, arst_n, in_valid && in_ready && in_data.cmd == CMD_TICK |=> !in_ready, "accepted during work")
	`ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid, "result during reset")
endmodule

bind shape_trajectory_generator_core stg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
